>>> hdl/spi_pkg.sv
// Shared types and constants for the segment pair intersection block.
package spi_pkg;

  localparam int OUT_W    = 32;  // width of a reported parameter
  localparam int TOL_W    = 25;  // width of both tolerance registers
  localparam int TOL_FRAC = 24;  // fraction bits of the parallel tolerance
  localparam int QB       = 33;  // quotient bits produced by the divider
  localparam int IDX_W    = 3;

  localparam logic [IDX_W-1:0] REG_REF_START_X = 3'd0;
  localparam logic [IDX_W-1:0] REG_REF_START_Y = 3'd1;
  localparam logic [IDX_W-1:0] REG_REF_END_X   = 3'd2;
  localparam logic [IDX_W-1:0] REG_REF_END_Y   = 3'd3;
  localparam logic [IDX_W-1:0] REG_SNAP_TOL    = 3'd4;
  localparam logic [IDX_W-1:0] REG_PAR_TOL     = 3'd5;

  typedef enum logic [1:0] {
    OUT_HIT      = 2'd0,
    OUT_MISS     = 2'd1,
    OUT_PARALLEL = 2'd2,
    OUT_ZERO_DEN = 2'd3
  } outcome_t;

  typedef struct packed {
    logic par;   // pair classified as parallel
    logic zero;  // common denominator is zero
  } front_flags_t;

endpackage

>>> hdl/segment_pair_intersection.sv
// Top level of the segment pair intersection block.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-----------------------------------
//  in_     | request   | in_valid / in_ready   | test segment, four Q16.16 coords
//  out_    | result    | out_valid / out_ready | outcome, crosses, params, touch
//  cfg_    | write     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One request enters per cycle while in_ready is high. A request passes the front
// pipeline, the queue and the back pipeline, whose length is set by the 33-stage quotient pipeline.
// Reset clears valid state and loads register defaults; no clearing pass.
// A stalled output holds the back pipeline; a full queue holds the front one
// and drops in_ready, so each side stalls on its own.
module segment_pair_intersection #(
  parameter int COORD_WIDTH     = 32,
  parameter int PARAM_FRAC_BITS = 24
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic signed [COORD_WIDTH-1:0]   in_test_start_x,
  input  logic signed [COORD_WIDTH-1:0]   in_test_start_y,
  input  logic signed [COORD_WIDTH-1:0]   in_test_end_x,
  input  logic signed [COORD_WIDTH-1:0]   in_test_end_y,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [1:0]                      out_outcome,
  output logic                            out_crosses,
  output logic signed [spi_pkg::OUT_W-1:0] out_ref_param,
  output logic signed [spi_pkg::OUT_W-1:0] out_test_param,
  output logic                            out_endpoint_touch,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [spi_pkg::IDX_W-1:0]       cfg_index,
  input  logic [((COORD_WIDTH > spi_pkg::TOL_W) ? COORD_WIDTH : spi_pkg::TOL_W)-1:0] cfg_data
);
  localparam int CW = COORD_WIDTH;
  localparam int SW = 2 * CW + 3;
  localparam int FLW = $bits(spi_pkg::front_flags_t);
  localparam int QW = FLW + 3 * SW;

  logic signed [CW-1:0] rsx_r, rsy_r, rex_r, rey_r;
  logic [spi_pkg::TOL_W-1:0] snap_r, ptol_r;

  // register writes; always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rsx_r  <= '0;
      rsy_r  <= '0;
      rex_r  <= CW'(65536);
      rey_r  <= '0;
      snap_r <= spi_pkg::TOL_W'(17);
      ptol_r <= spi_pkg::TOL_W'(17);
    end else if (cfg_valid) begin
      case (cfg_index)
        spi_pkg::REG_REF_START_X: rsx_r  <= cfg_data[CW-1:0];
        spi_pkg::REG_REF_START_Y: rsy_r  <= cfg_data[CW-1:0];
        spi_pkg::REG_REF_END_X:   rex_r  <= cfg_data[CW-1:0];
        spi_pkg::REG_REF_END_Y:   rey_r  <= cfg_data[CW-1:0];
        spi_pkg::REG_SNAP_TOL:    snap_r <= cfg_data[spi_pkg::TOL_W-1:0];
        spi_pkg::REG_PAR_TOL:     ptol_r <= cfg_data[spi_pkg::TOL_W-1:0];
        default: ;
      endcase
    end
  end

  // front side
  logic f_en, f_vld;
  spi_pkg::front_flags_t f_flags, b_flags;
  logic signed [SW-1:0] f_cr, f_nt, f_nu, b_cr, b_nt, b_nu;
  logic q_full, q_empty, q_push, q_pop;
  logic [QW-1:0] q_dout;

  // hold the whole front pipeline when its last stage cannot enter the queue
  assign f_en     = !(f_vld && q_full);
  assign in_ready = f_en;
  assign q_push   = f_vld && !q_full;

  spi_front #(.CW(CW)) u_front (
    .clk(clk), .rst_n(rst_n), .en(f_en), .in_vld(in_valid && in_ready),
    .rsx(rsx_r), .rsy(rsy_r), .rex(rex_r), .rey(rey_r),
    .tsx(in_test_start_x), .tsy(in_test_start_y),
    .tex(in_test_end_x), .tey(in_test_end_y),
    .ptol(ptol_r), .vld(f_vld), .flags(f_flags),
    .cr(f_cr), .numt(f_nt), .numu(f_nu)
  );

  spi_queue #(.W(QW), .DEPTH(4)) u_queue (
    .clk(clk), .rst_n(rst_n), .push(q_push), .din({f_flags, f_cr, f_nt, f_nu}),
    .full(q_full), .pop(q_pop), .dout(q_dout), .empty(q_empty)
  );

  assign {b_flags, b_cr, b_nt, b_nu} = q_dout;

  // back side: advance unless a finished result is still waiting
  logic b_en;
  assign b_en  = !(out_valid && !out_ready);
  assign q_pop = b_en && !q_empty;

  spi_back #(.CW(CW), .F(PARAM_FRAC_BITS)) u_back (
    .clk(clk), .rst_n(rst_n), .en(b_en), .in_vld(q_pop),
    .flags(b_flags), .cr(b_cr), .numt(b_nt), .numu(b_nu), .snap(snap_r),
    .vld(out_valid), .outcome(out_outcome), .crosses(out_crosses),
    .ref_param(out_ref_param), .test_param(out_test_param),
    .touch(out_endpoint_touch)
  );

  // queue must never take a request while full
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (f_vld && q_full) |-> !in_ready)
    else $error("front advanced into a full queue");

  // crosses tracks an intersecting outcome
  a_crosses: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_crosses == (out_outcome == spi_pkg::OUT_HIT)))
    else $error("crosses disagrees with outcome");

  // parallel results carry zero parameters
  a_parallel_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_outcome == spi_pkg::OUT_PARALLEL) |->
      (out_ref_param == '0 && out_test_param == '0 && !out_endpoint_touch))
    else $error("parallel result with nonzero fields");

  // a pop happens only from a non-empty queue while the back pipeline advances
  a_pop_enters: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty && b_en)
    else $error("pop from empty queue or while stalled");
endmodule

>>> hdl/spi_mul.sv
// Pipelined unsigned multiplier built from 32x32 digit products; it registers the digit products, then their sum.
module spi_mul #(
  parameter int AW = 32,
  parameter int BW = 32
) (
  input  logic          clk,
  input  logic          en,
  input  logic [AW-1:0] a,
  input  logic [BW-1:0] b,
  output logic [AW+BW-1:0] p
);
  localparam int NA = (AW + 31) / 32;
  localparam int NB = (BW + 31) / 32;
  localparam int PW = 32 * (NA + NB);

  logic [32*NA-1:0] a_pad;
  logic [32*NB-1:0] b_pad;
  logic [63:0]      pp_r [NA*NB];
  logic [PW-1:0]    sum;
  logic [AW+BW-1:0] p_r;

  assign a_pad = (32*NA)'(a);
  assign b_pad = (32*NB)'(b);

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pp_r[i*NB+j] <= a_pad[32*i +: 32] * b_pad[32*j +: 32];
        end
      end
    end
  end

  always_comb begin
    sum = '0;
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        sum = sum + (PW'(pp_r[i*NB+j]) << (32 * (i + j)));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= sum[AW+BW-1:0];
    end
  end

  assign p = p_r;
endmodule

>>> hdl/spi_front.sv
// Front pipeline: edge vectors, cross products and the parallel and zero-denominator tests.
module spi_front #(
  parameter int CW = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     in_vld,
  input  logic signed [CW-1:0]     rsx,
  input  logic signed [CW-1:0]     rsy,
  input  logic signed [CW-1:0]     rex,
  input  logic signed [CW-1:0]     rey,
  input  logic signed [CW-1:0]     tsx,
  input  logic signed [CW-1:0]     tsy,
  input  logic signed [CW-1:0]     tex,
  input  logic signed [CW-1:0]     tey,
  input  logic [spi_pkg::TOL_W-1:0] ptol,
  output logic                     vld,
  output spi_pkg::front_flags_t    flags,
  output logic signed [2*CW+2:0]   cr,
  output logic signed [2*CW+2:0]   numt,
  output logic signed [2*CW+2:0]   numu
);
  localparam int DW   = CW + 1;
  localparam int PW   = 2 * DW;
  localparam int SW   = PW + 1;
  localparam int MW   = PW;
  localparam int TW2  = 2 * spi_pkg::TOL_W;
  localparam int LW   = 2 * MW + 2 * spi_pkg::TOL_FRAC;
  localparam int RW   = TW2 + 2 * MW;
  localparam int CMPW = (LW > RW) ? LW : RW;

  logic [7:0] v_r;

  logic signed [DW-1:0] ax_r, ay_r, bx_r, by_r, dx_r, dy_r;
  logic signed [PW-1:0] pab_r, pba_r, pt0_r, pt1_r, pu0_r, pu1_r;
  logic signed [PW-1:0] axx_r, ayy_r, bxx_r, byy_r;
  logic signed [SW-1:0] cr_r, nt_r, nu_r;
  logic [MW-1:0]        crm_r, a2_r, b2_r;
  logic signed [SW-1:0] crd_r [4];
  logic signed [SW-1:0] ntd_r [4];
  logic signed [SW-1:0] nud_r [4];
  logic [2*MW-1:0]      cr2, ab2;
  logic [2*MW-1:0]      cr2d_r [2];
  logic [TW2-1:0]       tol2;
  logic [RW-1:0]        rhs;
  logic signed [SW-1:0] cr_s;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[6:0], in_vld};
    end
  end

  assign cr_s = (SW'(pab_r) - SW'(pba_r));

  always_ff @(posedge clk) begin
    if (en) begin
      ax_r  <= $signed({rex[CW-1], rex}) - $signed({rsx[CW-1], rsx});
      ay_r  <= $signed({rey[CW-1], rey}) - $signed({rsy[CW-1], rsy});
      bx_r  <= $signed({tex[CW-1], tex}) - $signed({tsx[CW-1], tsx});
      by_r  <= $signed({tey[CW-1], tey}) - $signed({tsy[CW-1], tsy});
      dx_r  <= $signed({tsx[CW-1], tsx}) - $signed({rsx[CW-1], rsx});
      dy_r  <= $signed({tsy[CW-1], tsy}) - $signed({rsy[CW-1], rsy});
      pab_r <= ax_r * by_r;
      pba_r <= ay_r * bx_r;
      pt0_r <= by_r * dx_r;
      pt1_r <= bx_r * dy_r;
      pu0_r <= ay_r * dx_r;
      pu1_r <= ax_r * dy_r;
      axx_r <= ax_r * ax_r;
      ayy_r <= ay_r * ay_r;
      bxx_r <= bx_r * bx_r;
      byy_r <= by_r * by_r;
      cr_r  <= cr_s;
      nt_r  <= SW'(pt0_r) - SW'(pt1_r);
      nu_r  <= SW'(pu0_r) - SW'(pu1_r);
      crm_r <= cr_s[SW-1] ? MW'(-cr_s) : MW'(cr_s);
      a2_r  <= $unsigned(axx_r) + $unsigned(ayy_r);
      b2_r  <= $unsigned(bxx_r) + $unsigned(byy_r);
      crd_r[0] <= cr_r;
      ntd_r[0] <= nt_r;
      nud_r[0] <= nu_r;
      for (int k = 1; k < 4; k++) begin
        crd_r[k] <= crd_r[k-1];
        ntd_r[k] <= ntd_r[k-1];
        nud_r[k] <= nud_r[k-1];
      end
      cr2d_r[0] <= cr2;
      cr2d_r[1] <= cr2d_r[0];
    end
  end

  spi_mul #(.AW(MW), .BW(MW)) u_cr2 (
    .clk(clk), .en(en), .a(crm_r), .b(crm_r), .p(cr2)
  );
  spi_mul #(.AW(MW), .BW(MW)) u_ab2 (
    .clk(clk), .en(en), .a(a2_r), .b(b2_r), .p(ab2)
  );
  spi_mul #(.AW(spi_pkg::TOL_W), .BW(spi_pkg::TOL_W)) u_tol2 (
    .clk(clk), .en(en), .a(ptol), .b(ptol), .p(tol2)
  );
  spi_mul #(.AW(TW2), .BW(2*MW)) u_rhs (
    .clk(clk), .en(en), .a(tol2), .b(ab2), .p(rhs)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      flags.par  <= (CMPW'(cr2d_r[1]) << (2 * spi_pkg::TOL_FRAC)) <= CMPW'(rhs);
      flags.zero <= (crd_r[3] == '0);
      cr         <= crd_r[3];
      numt       <= ntd_r[3];
      numu       <= nud_r[3];
    end
  end

  assign vld = v_r[7];
endmodule

>>> hdl/spi_queue.sv
// Small register queue between the front and back pipelines.
module spi_queue #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         empty
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNW = $clog2(DEPTH + 1);

  logic [W-1:0]   mem_r [DEPTH];
  logic [AW-1:0]  wp_r, rp_r;
  logic [CNW-1:0] cnt_r;

  function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= bump(wp_r);
      if (pop)  rp_r <= bump(rp_r);
      if (push && !pop) cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= din;
  end

  assign dout  = mem_r[rp_r];
  assign full  = (cnt_r == CNW'(DEPTH));
  assign empty = (cnt_r == '0);
endmodule

>>> hdl/spi_back.sv
// Back pipeline: staged restoring division, snapping, saturation, result.
module spi_back #(
  parameter int CW = 32,
  parameter int F  = 24
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      in_vld,
  input  spi_pkg::front_flags_t     flags,
  input  logic signed [2*CW+2:0]    cr,
  input  logic signed [2*CW+2:0]    numt,
  input  logic signed [2*CW+2:0]    numu,
  input  logic [spi_pkg::TOL_W-1:0] snap,
  output logic                      vld,
  output logic [1:0]                outcome,
  output logic                      crosses,
  output logic [spi_pkg::OUT_W-1:0] ref_param,
  output logic [spi_pkg::OUT_W-1:0] test_param,
  output logic                      touch
);
  localparam int QB = spi_pkg::QB;
  localparam int OW = spi_pkg::OUT_W;
  localparam int SW = 2 * CW + 3;
  localparam int MW = SW - 1;
  localparam int NW = MW + F;

  logic [QB+1:0] v_r;

  logic [MW-1:0] r_r   [2][QB+1];
  logic [QB-1:0] q_r   [2][QB+1];
  logic [QB-1:0] nlo_r [2][QB+1];
  logic          ov_r  [2][QB+1];
  logic          ng_r  [2][QB+1];
  logic [MW-1:0] dm_r  [QB+1];
  spi_pkg::front_flags_t fl_r [QB+1];

  logic [MW-1:0] dm_in;
  logic [MW-1:0] nm_in [2];
  logic [NW-1:0] n_in  [2];
  logic [NW-1:0] top_in [2];
  logic [MW:0]   r2    [2][QB];
  logic          ge    [2][QB];

  logic [QB:0]   qm [2];
  logic [QB+1:0] sn [2];
  logic [QB:0]   one;
  logic          in_range, ends;
  spi_pkg::outcome_t oc;

  assign one   = (QB+1)'(1) << F;
  assign dm_in = cr[SW-1] ? MW'(-cr) : MW'(cr);
  assign nm_in[0] = numt[SW-1] ? MW'(-numt) : MW'(numt);
  assign nm_in[1] = numu[SW-1] ? MW'(-numu) : MW'(numu);

  always_comb begin
    for (int p = 0; p < 2; p++) begin
      n_in[p]   = NW'(nm_in[p]) << F;
      top_in[p] = n_in[p] >> QB;
      for (int k = 0; k < QB; k++) begin
        r2[p][k] = {r_r[p][k], nlo_r[p][k][QB-1]};
        ge[p][k] = (r2[p][k] >= {1'b0, dm_r[k]});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[QB:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dm_r[0] <= dm_in;
      fl_r[0] <= flags;
      ng_r[0][0] <= numt[SW-1] ^ cr[SW-1];
      ng_r[1][0] <= numu[SW-1] ^ cr[SW-1];
      for (int p = 0; p < 2; p++) begin
        ov_r[p][0]  <= top_in[p] >= NW'(dm_in);
        r_r[p][0]   <= top_in[p][MW-1:0];
        nlo_r[p][0] <= n_in[p][QB-1:0];
        q_r[p][0]   <= '0;
      end
      for (int k = 0; k < QB; k++) begin
        dm_r[k+1] <= dm_r[k];
        fl_r[k+1] <= fl_r[k];
        for (int p = 0; p < 2; p++) begin
          ov_r[p][k+1]  <= ov_r[p][k];
          ng_r[p][k+1]  <= ng_r[p][k];
          nlo_r[p][k+1] <= nlo_r[p][k] << 1;
          q_r[p][k+1]   <= {q_r[p][k][QB-2:0], ge[p][k]};
          r_r[p][k+1]   <= ge[p][k] ? MW'(r2[p][k] - {1'b0, dm_r[k]}) : r2[p][k][MW-1:0];
        end
      end
    end
  end

  // snapped sign and magnitude, sign in the top bit
  function automatic logic [QB+1:0] snap_q(input logic [QB:0] m, input logic ng,
                                           input logic [spi_pkg::TOL_W-1:0] s,
                                           input logic [QB:0] o);
    logic [QB+1:0] dif;
    logic [QB:0]   st;
    st  = (QB+1)'(s);
    if (m < st) return '0;
    if (ng) dif = {1'b0, m} + {1'b0, o};
    else if (m >= o) dif = {1'b0, m - o};
    else dif = {1'b0, o - m};
    if (dif < {1'b0, st}) return {1'b0, o};
    return {ng && (m != '0), m};
  endfunction

  function automatic logic [OW-1:0] sat(input logic [QB+1:0] x);
    logic [QB:0] m;
    m = x[QB:0];
    if (!x[QB+1]) begin
      if (m > (QB+1)'({1'b0, {(OW-1){1'b1}}})) return {1'b0, {(OW-1){1'b1}}};
      return m[OW-1:0];
    end
    if (m > ((QB+1)'(1) << (OW - 1))) return {1'b1, {(OW-1){1'b0}}};
    return ~m[OW-1:0] + 1'b1;
  endfunction

  always_comb begin
    for (int p = 0; p < 2; p++) begin
      qm[p] = ov_r[p][QB] ? ((QB+1)'(1) << QB) : {1'b0, q_r[p][QB]};
      sn[p] = snap_q(qm[p], ng_r[p][QB], snap, one);
    end
    in_range = !sn[0][QB+1] && (sn[0][QB:0] <= one) &&
               !sn[1][QB+1] && (sn[1][QB:0] <= one);
    ends   = ((sn[0][QB:0] == '0) || (!sn[0][QB+1] && sn[0][QB:0] == one)) &&
             ((sn[1][QB:0] == '0) || (!sn[1][QB+1] && sn[1][QB:0] == one));
    if (fl_r[QB].par)       oc = spi_pkg::OUT_PARALLEL;
    else if (fl_r[QB].zero) oc = spi_pkg::OUT_ZERO_DEN;
    else if (in_range)      oc = spi_pkg::OUT_HIT;
    else                    oc = spi_pkg::OUT_MISS;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      outcome <= oc;
      if (oc == spi_pkg::OUT_HIT || oc == spi_pkg::OUT_MISS) begin
        crosses    <= in_range;
        ref_param  <= sat(sn[0]);
        test_param <= sat(sn[1]);
        touch      <= ends;
      end else begin
        crosses    <= 1'b0;
        ref_param  <= '0;
        test_param <= '0;
        touch      <= 1'b0;
      end
    end
  end

  assign vld = v_r[QB+1];
endmodule
